[rtl/nnis_pkg.sv]
// Shared types and constants of the nearest-neighbor image scaler.
package nnis_pkg;

  localparam int MAX_SIDE       = 256;
  localparam int PIXEL_BITS     = 32;
  localparam int SIDE_BITS      = $clog2(MAX_SIDE) + 1;
  localparam int IDX_BITS       = $clog2(MAX_SIDE);
  localparam int ADDR_BITS      = 2 * IDX_BITS;
  localparam int TARGET_BITS    = 15;
  localparam int REM_BITS       = TARGET_BITS + 1;
  localparam int QUOT_BITS      = SIDE_BITS;
  localparam int DVS_BITS       = TARGET_BITS + QUOT_BITS - 1;
  localparam int STEP_CNT_BITS  = $clog2(QUOT_BITS);
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = TARGET_BITS;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_WIDTH  = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_HEIGHT = 2'd3;

  typedef struct packed {
    logic                  kind;
    logic [PIXEL_BITS-1:0] pixel_in;
  } item_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_out;
    logic                  frame_end;
    logic                  error;
  } result_t;

  typedef struct packed {
    logic                   start;
    logic [REM_BITS-1:0]    dividend;
    logic [TARGET_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [QUOT_BITS-1:0] quotient;
    logic [REM_BITS-1:0]  remainder;
  } div_rsp_t;

endpackage

[rtl/nearest_neighbor_image_scaler.sv]
// Top level of the nearest-neighbor image scaler: image store, read walk and result port.
//
// Timing for users of this block: a load transaction (kind 0) writes one source pixel into the
// 65536-word image store and never raises busy, so loads can be issued back to back. A read
// transaction (kind 1) produces exactly one result, strobed by done for a single cycle, once
// it has passed the store read register and then the result register. The receiver cannot
// stall and must take the result then.
// A read while the target width or height is zero returns an error result and leaves busy low.
// A read on the last pixel of a frame also leaves busy low. Every other read keeps busy high
// while the source column or row index is advanced: the walk adds the source size to a
// remainder accumulator and divides by the target size, and that division runs in a
// bit-serial divider producing one quotient bit per cycle. The divider is loaded at the
// accepting edge, produces its nine quotient bits and raises done; the walk then takes
// its answer and drops busy.
// The image store needs no clearing after reset; reading a location never loaded yields an
// undefined pixel. Configuration writes are taken only while busy and start are both low, and
// every write restarts both the load address and the read walk at the top-left pixel.
module nearest_neighbor_image_scaler (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  nnis_pkg::item_t                      item,
  output logic                                 done,
  output nnis_pkg::result_t                    result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [nnis_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [nnis_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  typedef enum logic {
    ST_IDLE,
    ST_STEP
  } state_t;

  localparam int STORE_DEPTH = 1 << nnis_pkg::ADDR_BITS;

  // Source sizes outside 1..MAX_SIDE behave as the nearest legal size.
  function automatic logic [nnis_pkg::SIDE_BITS-1:0] side_clamp(
    input logic [nnis_pkg::SIDE_BITS-1:0] v
  );
    logic [nnis_pkg::SIDE_BITS-1:0] r;
    r = v;
    if (v == '0) begin
      r = nnis_pkg::SIDE_BITS'(1);
    end else if (v > nnis_pkg::SIDE_BITS'(nnis_pkg::MAX_SIDE)) begin
      r = nnis_pkg::SIDE_BITS'(nnis_pkg::MAX_SIDE);
    end
    return r;
  endfunction

  state_t                             state;
  logic [nnis_pkg::SIDE_BITS-1:0]     source_width;
  logic [nnis_pkg::SIDE_BITS-1:0]     source_height;
  logic [nnis_pkg::TARGET_BITS-1:0]   target_width;
  logic [nnis_pkg::TARGET_BITS-1:0]   target_height;
  logic [nnis_pkg::ADDR_BITS-1:0]     load_address;
  logic [nnis_pkg::TARGET_BITS-1:0]   out_column;
  logic [nnis_pkg::TARGET_BITS-1:0]   out_row;
  logic [nnis_pkg::IDX_BITS-1:0]      src_column;
  logic [nnis_pkg::IDX_BITS-1:0]      src_row;
  logic [nnis_pkg::TARGET_BITS-1:0]   column_remainder;
  logic [nnis_pkg::TARGET_BITS-1:0]   row_remainder;
  logic                               step_row;
  logic                               pend_valid;
  logic                               pend_error;
  logic                               pend_last;
  logic [nnis_pkg::PIXEL_BITS-1:0]    rd_data;
  logic [nnis_pkg::PIXEL_BITS-1:0]    image_store [STORE_DEPTH];

  logic                               accept;
  logic                               load_en;
  logic                               read_en;
  logic                               target_zero;
  logic [nnis_pkg::SIDE_BITS-1:0]     sw;
  logic [nnis_pkg::SIDE_BITS-1:0]     sh;
  logic [nnis_pkg::TARGET_BITS:0]     column_plus;
  logic [nnis_pkg::TARGET_BITS:0]     row_plus;
  logic                               column_step;
  logic                               row_step;
  logic                               last;
  logic [nnis_pkg::ADDR_BITS-1:0]     rd_product;
  logic [nnis_pkg::ADDR_BITS-1:0]     rd_addr;
  nnis_pkg::div_req_t                 div_req;
  nnis_pkg::div_rsp_t                 div_rsp;

  // A register write never shares an edge with an item transaction.
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE) && !start;
  assign accept    = start && !busy;
  assign load_en   = accept && (item.kind == nnis_pkg::KIND_LOAD);
  assign read_en   = accept && (item.kind == nnis_pkg::KIND_READ);

  assign sw          = side_clamp(source_width);
  assign sh          = side_clamp(source_height);
  assign target_zero = (target_width == '0) || (target_height == '0);
  assign column_plus = {1'b0, out_column} + 1'b1;
  assign row_plus    = {1'b0, out_row} + 1'b1;
  assign column_step = column_plus < {1'b0, target_width};
  assign row_step    = row_plus < {1'b0, target_height};
  assign last        = (column_plus == {1'b0, target_width}) &&
                       (row_plus == {1'b0, target_height});

  // Row base plus column; the row index stays below the source height, so this fits the store.
  assign rd_product = {{(nnis_pkg::ADDR_BITS-nnis_pkg::IDX_BITS){1'b0}}, src_row} *
                      {{(nnis_pkg::ADDR_BITS-nnis_pkg::SIDE_BITS){1'b0}}, sw};
  assign rd_addr    = rd_product +
                      {{(nnis_pkg::ADDR_BITS-nnis_pkg::IDX_BITS){1'b0}}, src_column};

  // A column advance when the row is not finished, otherwise a row advance.
  always_comb begin
    div_req.start = read_en && !target_zero && (column_step || row_step);
    if (column_step) begin
      div_req.dividend = {1'b0, column_remainder} +
                         {{(nnis_pkg::REM_BITS-nnis_pkg::SIDE_BITS){1'b0}}, sw};
      div_req.divisor  = target_width;
    end else begin
      div_req.dividend = {1'b0, row_remainder} +
                         {{(nnis_pkg::REM_BITS-nnis_pkg::SIDE_BITS){1'b0}}, sh};
      div_req.divisor  = target_height;
    end
  end

  nnis_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Image store: one write port for loads, one registered read port for the walk.
  always_ff @(posedge clk) begin
    if (load_en) begin
      image_store[load_address] <= item.pixel_in;
    end
    if (read_en) begin
      rd_data <= image_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      source_width     <= nnis_pkg::SIDE_BITS'(nnis_pkg::MAX_SIDE);
      source_height    <= nnis_pkg::SIDE_BITS'(nnis_pkg::MAX_SIDE);
      target_width     <= nnis_pkg::TARGET_BITS'(256);
      target_height    <= nnis_pkg::TARGET_BITS'(256);
      load_address     <= '0;
      out_column       <= '0;
      out_row          <= '0;
      src_column       <= '0;
      src_row          <= '0;
      column_remainder <= '0;
      row_remainder    <= '0;
      step_row         <= 1'b0;
      pend_valid       <= 1'b0;
      pend_error       <= 1'b0;
      pend_last        <= 1'b0;
      done             <= 1'b0;
    end else begin
      done       <= pend_valid;
      pend_valid <= read_en;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          nnis_pkg::REG_SOURCE_WIDTH:  source_width  <= cfg_data[nnis_pkg::SIDE_BITS-1:0];
          nnis_pkg::REG_SOURCE_HEIGHT: source_height <= cfg_data[nnis_pkg::SIDE_BITS-1:0];
          nnis_pkg::REG_TARGET_WIDTH:  target_width  <= cfg_data[nnis_pkg::TARGET_BITS-1:0];
          nnis_pkg::REG_TARGET_HEIGHT: target_height <= cfg_data[nnis_pkg::TARGET_BITS-1:0];
          default: ;
        endcase
        load_address     <= '0;
        out_column       <= '0;
        out_row          <= '0;
        src_column       <= '0;
        src_row          <= '0;
        column_remainder <= '0;
        row_remainder    <= '0;
      end

      if (load_en) begin
        load_address <= load_address + 1'b1;
      end

      if (read_en) begin
        pend_error <= target_zero;
        pend_last  <= last && !target_zero;
        if (!target_zero) begin
          if (column_step) begin
            out_column <= column_plus[nnis_pkg::TARGET_BITS-1:0];
            step_row   <= 1'b0;
            state      <= ST_STEP;
          end else begin
            out_column       <= '0;
            src_column       <= '0;
            column_remainder <= '0;
            if (row_step) begin
              out_row  <= row_plus[nnis_pkg::TARGET_BITS-1:0];
              step_row <= 1'b1;
              state    <= ST_STEP;
            end else begin
              out_row       <= '0;
              src_row       <= '0;
              row_remainder <= '0;
            end
          end
        end
      end

      if ((state == ST_STEP) && div_rsp.done) begin
        if (step_row) begin
          src_row       <= src_row + div_rsp.quotient[nnis_pkg::IDX_BITS-1:0];
          row_remainder <= div_rsp.remainder[nnis_pkg::TARGET_BITS-1:0];
        end else begin
          src_column       <= src_column + div_rsp.quotient[nnis_pkg::IDX_BITS-1:0];
          column_remainder <= div_rsp.remainder[nnis_pkg::TARGET_BITS-1:0];
        end
        state <= ST_IDLE;
      end
    end
  end

  // The result register is loaded in the cycle after the read is accepted, when the store data is ready.
  always_ff @(posedge clk) begin
    if (pend_valid) begin
      if (pend_error) begin
        result.pixel_out <= '0;
        result.frame_end <= 1'b0;
        result.error     <= 1'b1;
      end else begin
        result.pixel_out <= rd_data;
        result.frame_end <= pend_last;
        result.error     <= 1'b0;
      end
    end
  end

endmodule

[rtl/nnis_divider.sv]
// Bit-serial restoring divider that advances one remainder accumulator.
module nnis_divider (
  input  logic              clk,
  input  logic              rst,
  input  nnis_pkg::div_req_t req,
  output nnis_pkg::div_rsp_t rsp
);

  logic                                  running;
  logic [nnis_pkg::STEP_CNT_BITS-1:0]    count;
  logic [nnis_pkg::REM_BITS-1:0]         rem;
  logic [nnis_pkg::DVS_BITS-1:0]         dvs;
  logic [nnis_pkg::QUOT_BITS-1:0]        quot;
  logic                                  done;
  logic                                  fits;
  logic [nnis_pkg::DVS_BITS-1:0]         diff;

  // Trial subtraction of the shifted divisor.
  assign fits = {{(nnis_pkg::DVS_BITS-nnis_pkg::REM_BITS){1'b0}}, rem} >= dvs;
  assign diff = {{(nnis_pkg::DVS_BITS-nnis_pkg::REM_BITS){1'b0}}, rem} - dvs;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        count   <= nnis_pkg::STEP_CNT_BITS'(nnis_pkg::QUOT_BITS - 1);
        rem     <= req.dividend;
        dvs     <= {req.divisor, {(nnis_pkg::QUOT_BITS-1){1'b0}}};
        quot    <= '0;
      end else if (running) begin
        if (fits) begin
          rem <= diff[nnis_pkg::REM_BITS-1:0];
        end
        quot <= {quot[nnis_pkg::QUOT_BITS-2:0], fits};
        dvs  <= dvs >> 1;
        if (count == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          count <= count - 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quot;
  assign rsp.remainder = rem;

endmodule

[rtl/nnis_checker.sv]
// Port-level assertions for the nearest-neighbor image scaler, bound to the top level.
module nnis_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input nnis_pkg::item_t                     item,
  input logic                                done,
  input nnis_pkg::result_t                   result,
  input logic                                cfg_valid,
  input logic                                cfg_ready,
  input logic [nnis_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input logic [nnis_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  // Every result answers an accepted read transaction, delayed through pend_valid and done.
  a_done_follows_read: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && (item.kind == nnis_pkg::KIND_READ), 2))
    else $error("result without a preceding read transaction");

  // An error result carries a zero pixel and never ends a frame.
  a_error_payload: assert property (@(posedge clk) disable iff (rst)
    (done && result.error) |-> ((result.pixel_out == '0) && !result.frame_end))
    else $error("error result with nonzero payload");

  // Only an accepted read can make the block busy.
  a_busy_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && (item.kind == nnis_pkg::KIND_READ)))
    else $error("busy raised without a read transaction");

  // The configuration channel is closed while a read is being worked on.
  a_cfg_closed_when_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cfg_ready)
    else $error("configuration accepted while busy");

endmodule

bind nearest_neighbor_image_scaler nnis_checker u_nnis_checker (.*);

[tb/tb.sv]
// Self-checking testbench for the nearest-neighbor image scaler.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nnis_pkg::*;

  // Cycles a non-final read keeps the block busy, plus margin. Used before register writes
  // and at the end of the run, because loads and the tail of a read produce no result.
  localparam int SETTLE_CYCLES  = 14;
  // Longest stretch with no transaction of any kind before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int STORE_WORDS    = MAX_SIDE * MAX_SIDE;
  localparam int RANDOM_ITEMS   = 360;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  item_t                     item;
  logic                      done;
  result_t                   result;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  nearest_neighbor_image_scaler DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6ns;
    clk = 1'b1;
    #6ns;
  end

  // ---------------------------------------------------------------------------------------
  // Predicted state of the scaler. The image copy starts unknown; a map of loaded words
  // keeps every read off locations that were never loaded.
  // ---------------------------------------------------------------------------------------
  logic [PIXEL_BITS-1:0]  image_copy [0:STORE_WORDS-1];
  bit                     loaded [0:STORE_WORDS-1];
  logic [ADDR_BITS-1:0]   next_load;
  int unsigned            dst_col, dst_row;
  int unsigned            pick_col, pick_row;
  int unsigned            col_rem, row_rem;
  logic [SIDE_BITS-1:0]   src_w_reg, src_h_reg;
  logic [TARGET_BITS-1:0] dst_w_reg, dst_h_reg;

  // Expected results in the order the reads were accepted.
  result_t pending_pixels[$];

  int  fail_count;
  int  items_sent;
  int  idle_cycles;
  int  burst_left;
  // When set, the sender issues items back to back with no gaps.
  bit  sender_steady;

  // A source side of zero behaves as one pixel; anything past the store side saturates.
  function automatic int unsigned clamp_side(input logic [SIDE_BITS-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return v;
  endfunction

  // True when the next read is an error read or lands on a word that has been loaded.
  function automatic bit read_is_safe();
    int unsigned sw, addr;
    sw = clamp_side(src_w_reg);
    if (dst_w_reg == '0 || dst_h_reg == '0) return 1'b1;
    addr = (pick_row * sw + pick_col) % STORE_WORDS;
    return loaded[addr];
  endfunction

  // Advances the predicted state by one accepted transaction and queues the result that a
  // read must produce. Loads go to the next store word, wrapping round the whole store.
  // Reads walk the destination in raster order; each source index advances by the integer
  // part of (remainder + source side) / target side, the fraction kept as the remainder.
  task automatic scale_step(input item_t it);
    int unsigned sw, sh, tw, th, acc, addr;
    result_t     want;
    sw = clamp_side(src_w_reg);
    sh = clamp_side(src_h_reg);
    tw = dst_w_reg;
    th = dst_h_reg;
    if (it.kind == KIND_LOAD) begin
      image_copy[next_load] = it.pixel_in;
      loaded[next_load]     = 1'b1;
      next_load = next_load + 1'b1;
    end else if (tw == 0 || th == 0) begin
      // An empty destination answers an error with zero data and moves nothing.
      want.pixel_out = '0;
      want.frame_end = 1'b0;
      want.error     = 1'b1;
      pending_pixels.push_back(want);
    end else begin
      addr = (pick_row * sw + pick_col) % STORE_WORDS;
      want.pixel_out = image_copy[addr];
      want.frame_end = (dst_col + 1 == tw) && (dst_row + 1 == th);
      want.error     = 1'b0;
      pending_pixels.push_back(want);
      if (dst_col + 1 < tw) begin
        acc = col_rem + sw;
        dst_col++;
        pick_col += acc / tw;
        col_rem = acc % tw;
      end else begin
        dst_col  = 0;
        pick_col = 0;
        col_rem  = 0;
        if (dst_row + 1 < th) begin
          acc = row_rem + sh;
          dst_row++;
          pick_row += acc / th;
          row_rem = acc % th;
        end else begin
          // Past the last pixel the walk returns to the top-left corner.
          dst_row  = 0;
          pick_row = 0;
          row_rem  = 0;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Result checker. The receiver cannot stall, so every strobed result is taken at the
  // edge that ends its cycle and compared against the oldest outstanding expectation.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && done === 1'b1) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result: pixel_out %h frame_end %b error %b",
               result.pixel_out, result.frame_end, result.error);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (result.pixel_out !== want.pixel_out) begin
          $error("pixel_out expected %h actual %h", want.pixel_out, result.pixel_out);
          fail_count++;
        end
        if (result.frame_end !== want.frame_end) begin
          $error("frame_end expected %b actual %b", want.frame_end, result.frame_end);
          fail_count++;
        end
        if (result.error !== want.error) begin
          $error("error expected %b actual %b", want.error, result.error);
          fail_count++;
        end
      end
    end
  end

  // The watchdog measures stretches in which no transaction of any kind completes.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("nearest_neighbor_image_scaler regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers. Every helper is entered just after a falling edge and returns just
  // after one, so inputs only ever change half a cycle away from the sampling edge.
  // ---------------------------------------------------------------------------------------

  // Sends one item. The sender works in bursts: at the start of each burst it may idle for
  // a random gap, which shifts where the next item lands within a read. The item is held
  // until the block drops busy; the prediction is updated at the accepting edge.
  task automatic send_item(input logic kind, input logic [PIXEL_BITS-1:0] pixel);
    int gap;
    if (!sender_steady) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
        burst_left = $urandom_range(1, 40);
        if (gap > 0) begin
          start = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst_left--;
    end
    start         = 1'b1;
    item.kind     = kind;
    item.pixel_in = pixel;
    do @(posedge clk); while (busy);
    scale_step(item);
    items_sent++;
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic load_pixels(input int count);
    repeat (count) send_item(KIND_LOAD, $urandom());
  endtask

  // Reads stop early once the walk would reach a word that was never loaded.
  task automatic read_pixels(input int count);
    for (int i = 0; i < count && read_is_safe(); i++) begin
      send_item(KIND_READ, $urandom());
    end
  endtask

  // Waits until every expected result has come back and the block has had time to finish
  // the tail of its last read, which produces no further result.
  task automatic settle();
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes one register while the block is idle. Any write also restarts the load address
  // and the read walk, which the prediction mirrors.
  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                input logic [CFG_DATA_BITS-1:0] data);
    settle();
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      REG_SOURCE_WIDTH:  src_w_reg = data[SIDE_BITS-1:0];
      REG_SOURCE_HEIGHT: src_h_reg = data[SIDE_BITS-1:0];
      REG_TARGET_WIDTH:  dst_w_reg = data;
      REG_TARGET_HEIGHT: dst_h_reg = data;
      default: ;
    endcase
    next_load = '0;
    dst_col   = 0;
    dst_row   = 0;
    pick_col  = 0;
    pick_row  = 0;
    col_rem   = 0;
    row_rem   = 0;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_geometry(input logic [CFG_DATA_BITS-1:0] sw, input logic [CFG_DATA_BITS-1:0] sh,
                              input logic [CFG_DATA_BITS-1:0] tw, input logic [CFG_DATA_BITS-1:0] th);
    write_register(REG_SOURCE_WIDTH, sw);
    write_register(REG_SOURCE_HEIGHT, sh);
    write_register(REG_TARGET_WIDTH, tw);
    write_register(REG_TARGET_HEIGHT, th);
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------------------

  // With the reset geometry (256x256 to 256x256) the walk is the identity, so the first
  // row of reads returns the loaded words in order, all-zero and all-one words included.
  task automatic test_reset_geometry();
    send_item(KIND_LOAD, '0);
    send_item(KIND_LOAD, '1);
    load_pixels(20);
    send_item(KIND_LOAD, 32'h8000_0001);
    read_pixels(20);
  endtask

  // A zero target width or height turns reads into errors with zero data, and loads keep
  // working meanwhile. A full 3x3 frame afterwards ends with the frame-end flag, and one
  // more read shows the walk back at the corner.
  task automatic test_empty_target();
    set_geometry(2, 2, 3, 3);
    send_item(KIND_LOAD, '1);
    load_pixels(3);
    read_pixels(2);
    write_register(REG_TARGET_HEIGHT, 0);
    read_pixels(2);
    load_pixels(1);
    read_pixels(1);
    write_register(REG_TARGET_HEIGHT, 3);
    write_register(REG_TARGET_WIDTH, 0);
    read_pixels(2);
    write_register(REG_TARGET_WIDTH, 3);
    read_pixels(10);
  endtask

  // Source sizes written with bits above the register width, zero, or past the store side.
  // Zero acts as one pixel, oversize acts as the full side; high data bits are dropped.
  // The targets are chosen so that a clamped side walks differently from an unclamped one.
  task automatic test_source_clamp();
    set_geometry(15'h7E00, 15'h01FF, 2, 300);
    load_pixels(8);
    read_pixels(10);
    set_geometry(15'h0101, 15'h7C00, 257, 1);
    load_pixels(8);
    read_pixels(6);
  endtask

  // Smallest and largest destinations: a 1x1 target flags every read as frame end, and the
  // largest target steps the source by tiny fractions.
  task automatic test_target_extremes();
    set_geometry(3, 2, 1, 1);
    send_item(KIND_LOAD, '1);
    send_item(KIND_LOAD, '0);
    load_pixels(4);
    read_pixels(3);
    set_geometry(256, 256, 32767, 32767);
    read_pixels(6);
    set_geometry(1, 256, 32767, 1);
    read_pixels(4);
  endtask

  function automatic logic [CFG_DATA_BITS-1:0] pick_source_side();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return MAX_SIDE;
      2:       return $urandom_range(0, 32767);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_target_side();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(0, 32767);
      3:       return 1;
      default: return $urandom_range(1, 9);
    endcase
  endfunction

  // Random phases. Each one rewrites some registers, loads a source image when it is small
  // enough, reads at least a whole frame when the frame is small (so frame ends and the
  // wrap back to the corner are hit often), then mixes in a few random items.
  task automatic test_random_frames();
    int                        first_item, count, n;
    int unsigned               src_area, dst_area;
    logic [CFG_INDEX_BITS-1:0] index;
    first_item = items_sent;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      sender_steady = ($urandom_range(0, 3) == 0);
      n = $urandom_range(1, 4);
      repeat (n) begin
        index = $urandom_range(0, 3);
        if (index == REG_SOURCE_WIDTH || index == REG_SOURCE_HEIGHT) begin
          write_register(index, pick_source_side());
        end else begin
          write_register(index, pick_target_side());
        end
      end
      src_area = clamp_side(src_w_reg) * clamp_side(src_h_reg);
      dst_area = dst_w_reg * dst_h_reg;
      load_pixels(src_area <= 64 ? src_area : $urandom_range(1, 16));
      if (dst_area == 0) begin
        count = $urandom_range(1, 4);
      end else if (dst_area <= 40) begin
        count = dst_area + $urandom_range(0, 3);
      end else begin
        count = $urandom_range(4, 24);
      end
      read_pixels(count);
      n = $urandom_range(0, 6);
      repeat (n) begin
        if ($urandom_range(0, 1) && read_is_safe()) begin
          send_item(KIND_READ, $urandom());
        end else begin
          send_item(KIND_LOAD, $urandom());
        end
      end
    end
    sender_steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------------------
  // Sequence: reset once, run the tests in turn, drain, report.
  // ---------------------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    item          = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    fail_count    = 0;
    items_sent    = 0;
    burst_left    = 0;
    sender_steady = 1'b0;
    // The prediction starts from the reset state of the block.
    next_load     = '0;
    dst_col       = 0;
    dst_row       = 0;
    pick_col      = 0;
    pick_row      = 0;
    col_rem       = 0;
    row_rem       = 0;
    src_w_reg     = MAX_SIDE;
    src_h_reg     = MAX_SIDE;
    dst_w_reg     = MAX_SIDE;
    dst_h_reg     = MAX_SIDE;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_geometry();
    test_empty_target();
    test_source_clamp();
    test_target_extremes();
    test_random_frames();

    settle();
    if (fail_count == 0) begin
      $display("nearest_neighbor_image_scaler regression: pass");
    end else begin
      $display("nearest_neighbor_image_scaler regression: fail");
    end
    $finish;
  end

endmodule
